// File: hdl/psc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, register codes and types for the sphere contact pipeline.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int COORD_BITS = 24;
    localparam int BOX_W      = 24;
    localparam int EPS_W      = 20;
    localparam int RAD_W      = 24;

    // a folded difference never exceeds the larger of coordinate range and box
    localparam int MAG_W   = (COORD_BITS > BOX_W) ? COORD_BITS : BOX_W;
    localparam int FOLD_W  = MAG_W + 2;
    localparam int RSUM_W  = RAD_W + 1;
    localparam int RSQ_W   = 2 * RSUM_W;
    localparam int LIM_W   = RSQ_W + 1;
    localparam int SQ1_W   = 2 * MAG_W;
    localparam int SQ_W    = 2 * MAG_W + 2;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int CMP_W   = (SQ_W > LIM_W) ? SQ_W : LIM_W;

    localparam int DSQ_W   = 50;
    localparam int DIST_W  = 25;

    localparam int S_FIELDS_W = 6 * COORD_BITS + 2 * RAD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DSQ_W + DIST_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_EDGE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_EPS = 1'd1;

    localparam logic [BOX_W-1:0] BOX_RESET = 24'hFFFFFF;
    localparam logic [EPS_W-1:0] EPS_RESET = 20'd1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [BOX_W-1:0] box_edge;
        logic [EPS_W-1:0] contact_epsilon;
    } cfg_t;

    typedef struct packed {
        logic             periodic;
        coord_t [2:0]     first;
        coord_t [2:0]     second;
        logic [RAD_W-1:0] first_radius;
        logic [RAD_W-1:0] second_radius;
    } pair_t;

    typedef struct packed {
        logic [SQ_W-1:0] dsq;
        logic            touching;
    } geom_out_t;

endpackage
`default_nettype wire

// File: hdl/psc_geom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_geom
// Six-stage datapath: differences, minimum-image fold, magnitude, squares,
// sum and contact compare.
// ----------------------------------------------------------------------------
module psc_geom (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire psc_pkg::cfg_t     cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire psc_pkg::pair_t    in_pair,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output psc_pkg::geom_out_t     out_res
);

    localparam int NSTG = 6;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] ready;

    // stage 0: raw differences and radius sum
    logic signed [psc_pkg::FOLD_W-1:0] diff0_reg [0:2];
    logic signed [psc_pkg::FOLD_W-1:0] diff0_next [0:2];
    logic [psc_pkg::RSUM_W-1:0]        rsum0_reg, rsum0_next;
    logic                              per0_reg;
    // stage 1: folded differences
    logic signed [psc_pkg::FOLD_W-1:0] fold1_reg [0:2];
    logic signed [psc_pkg::FOLD_W-1:0] fold1_next [0:2];
    logic [psc_pkg::RSUM_W-1:0]        rsum1_reg;
    // stage 2: magnitudes
    logic [psc_pkg::MAG_W-1:0]         mag2_reg [0:2];
    logic [psc_pkg::MAG_W-1:0]         mag2_next [0:2];
    logic [psc_pkg::RSUM_W-1:0]        rsum2_reg;
    // stage 3: squares
    logic [psc_pkg::SQ1_W-1:0]         sq3_reg [0:2];
    logic [psc_pkg::SQ1_W-1:0]         sq3_next [0:2];
    logic [psc_pkg::RSQ_W-1:0]         rsq3_reg, rsq3_next;
    // stage 4: sum and contact limit
    logic [psc_pkg::SQ_W-1:0]          dsq4_reg, dsq4_next;
    logic [psc_pkg::LIM_W-1:0]         lim4_reg, lim4_next;
    // stage 5: result
    logic [psc_pkg::SQ_W-1:0]          dsq5_reg;
    logic                              touch5_reg, touch5_next;

    // each stage moves when empty or when the stage after it moves
    always_comb begin
        ready[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NSTG; i++) begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff0_next[i] = psc_pkg::FOLD_W'(in_pair.first[i])
                          - psc_pkg::FOLD_W'(in_pair.second[i]);
        end
        rsum0_next = psc_pkg::RSUM_W'(in_pair.first_radius)
                   + psc_pkg::RSUM_W'(in_pair.second_radius);
    end

    always_comb begin
        logic signed [psc_pkg::FOLD_W:0]   twod;
        logic signed [psc_pkg::FOLD_W:0]   box_w;
        logic signed [psc_pkg::FOLD_W-1:0] box_f;
        box_w = $signed({{(psc_pkg::FOLD_W + 1 - psc_pkg::BOX_W){1'b0}}, cfg.box_edge});
        box_f = box_w[psc_pkg::FOLD_W-1:0];
        for (int i = 0; i < 3; i++) begin
            twod = {diff0_reg[i], 1'b0};
            if (per0_reg && (twod > box_w)) begin
                fold1_next[i] = diff0_reg[i] - box_f;
            end else if (per0_reg && (twod < -box_w)) begin
                fold1_next[i] = diff0_reg[i] + box_f;
            end else begin
                fold1_next[i] = diff0_reg[i];
            end
        end
    end

    always_comb begin
        logic signed [psc_pkg::FOLD_W-1:0] absv;
        for (int i = 0; i < 3; i++) begin
            absv = (fold1_reg[i] < 0) ? -fold1_reg[i] : fold1_reg[i];
            mag2_next[i] = absv[psc_pkg::MAG_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq3_next[i] = mag2_reg[i] * mag2_reg[i];
        end
        rsq3_next = rsum2_reg * rsum2_reg;
    end

    always_comb begin
        dsq4_next = psc_pkg::SQ_W'(sq3_reg[0]) + psc_pkg::SQ_W'(sq3_reg[1])
                  + psc_pkg::SQ_W'(sq3_reg[2]);
        lim4_next = psc_pkg::LIM_W'(rsq3_reg) + psc_pkg::LIM_W'(cfg.contact_epsilon);
        // at or below radius sum squared plus epsilon counts as contact
        touch5_next = psc_pkg::CMP_W'(dsq4_reg) <= psc_pkg::CMP_W'(lim4_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            diff0_reg <= diff0_next;
            rsum0_reg <= rsum0_next;
            per0_reg  <= in_pair.periodic;
        end
        if (ready[1]) begin
            fold1_reg <= fold1_next;
            rsum1_reg <= rsum0_reg;
        end
        if (ready[2]) begin
            mag2_reg  <= mag2_next;
            rsum2_reg <= rsum1_reg;
        end
        if (ready[3]) begin
            sq3_reg  <= sq3_next;
            rsq3_reg <= rsq3_next;
        end
        if (ready[4]) begin
            dsq4_reg <= dsq4_next;
            lim4_reg <= lim4_next;
        end
        if (ready[5]) begin
            dsq5_reg   <= dsq4_reg;
            touch5_reg <= touch5_next;
        end
    end

    assign in_ready          = ready[0];
    assign out_valid         = valid_reg[NSTG-1];
    assign out_res.dsq       = dsq5_reg;
    assign out_res.touching  = touch5_reg;

`ifndef SYNTH
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted item did not enter the first stage");

    a_zero_touches: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && (out_res.dsq == '0) |-> out_res.touching)
        else $error("coincident centres not flagged as contact");
`endif

endmodule
`default_nettype wire

// File: hdl/psc_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_sqrt
// Pipelined floor square root, one root bit per stage, with the squared
// distance and contact flag riding alongside.
// ----------------------------------------------------------------------------
module psc_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire psc_pkg::geom_out_t            in_res,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [psc_pkg::DSQ_W-1:0]          out_dsq,
    output logic [psc_pkg::DIST_W-1:0]         out_dist,
    output logic                               out_touching
);

    localparam int NSTG  = psc_pkg::ROOT_W;
    localparam int CHK_W = psc_pkg::SQ_W + 2;

    logic [NSTG-1:0]             valid_reg;
    logic [NSTG-1:0]             ready;
    logic [psc_pkg::SQ_W-1:0]    rem_reg   [0:NSTG-1];
    logic [psc_pkg::ROOT_W-1:0]  root_reg  [0:NSTG-1];
    logic [psc_pkg::SQ_W-1:0]    dsq_reg   [0:NSTG-1];
    logic                        touch_reg [0:NSTG-1];

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        localparam int K = NSTG - 1 - s;

        logic                        valid_in;
        logic                        ready_out;
        logic [psc_pkg::SQ_W-1:0]    rem_in;
        logic [psc_pkg::ROOT_W-1:0]  root_in;
        logic [psc_pkg::SQ_W-1:0]    dsq_in;
        logic                        touch_in;
        logic [psc_pkg::SQ_W:0]      trial;
        logic                        take;
        logic [psc_pkg::SQ_W-1:0]    rem_next;
        logic [psc_pkg::ROOT_W-1:0]  root_next;
        logic                        valid_next;

        if (s == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_res.dsq;
            assign root_in  = '0;
            assign dsq_in   = in_res.dsq;
            assign touch_in = in_res.touching;
        end else begin : g_next
            assign valid_in = valid_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign root_in  = root_reg[s-1];
            assign dsq_in   = dsq_reg[s-1];
            assign touch_in = touch_reg[s-1];
        end

        if (s == NSTG - 1) begin : g_last
            assign ready_out = out_ready;
        end else begin : g_mid
            assign ready_out = ready[s+1];
        end

        // (root + 2^K)^2 - root^2, root holds only bits above K
        always_comb begin
            trial = (psc_pkg::SQ_W'(root_in) << (K + 1))
                  | ((psc_pkg::SQ_W + 1)'(1) << (2 * K));
            take  = (psc_pkg::SQ_W + 1)'(rem_in) >= trial;
            rem_next  = take ? (rem_in - trial[psc_pkg::SQ_W-1:0]) : rem_in;
            root_next = take ? (root_in | (psc_pkg::ROOT_W'(1) << K)) : root_in;
            ready[s]   = !valid_reg[s] || ready_out;
            valid_next = ready[s] ? valid_in : valid_reg[s];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else begin
                valid_reg[s] <= valid_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (ready[s]) begin
                rem_reg[s]   <= rem_next;
                root_reg[s]  <= root_next;
                dsq_reg[s]   <= dsq_in;
                touch_reg[s] <= touch_in;
            end
        end
    end

    assign in_ready     = ready[0];
    assign out_valid    = valid_reg[NSTG-1];
    assign out_dsq      = dsq_reg[NSTG-1][psc_pkg::DSQ_W-1:0];
    assign out_dist     = root_reg[NSTG-1][psc_pkg::DIST_W-1:0];
    assign out_touching = touch_reg[NSTG-1];

`ifndef SYNTH
    a_root_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[NSTG-1] |->
            (CHK_W'(root_reg[NSTG-1]) * CHK_W'(root_reg[NSTG-1])
                <= CHK_W'(dsq_reg[NSTG-1]))
            && ((CHK_W'(root_reg[NSTG-1]) + CHK_W'(1))
                * (CHK_W'(root_reg[NSTG-1]) + CHK_W'(1))
                > CHK_W'(dsq_reg[NSTG-1])))
        else $error("square root result is not the floor root");
`endif

endmodule
`default_nettype wire

// File: hdl/periodic_sphere_contact.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_sphere_contact
// Squared centre distance, floor root and contact flag for a sphere pair,
// with optional minimum-image folding in a periodic cubic box.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one sphere pair per item; s_tuser = 1 selects plain
//   relative distance, 0 folds each difference into the periodic box.
//   m_ channel returns one item per input item, in order.
//   cfg channel writes the box edge (index 0) and contact_epsilon (index 1);
//   write only while no item is in flight. cfg_ready is always high.
// Pipeline: six datapath stages, then one stage per root bit.
// Throughput: one item per cycle while m_tready is high; each stage holds a single item.
// Reset: clears all stage valid bits, box edge to 16777215, epsilon to 1.
// Stall: while m_tready is low the output holds; empty stages further up
//   keep filling, and s_tready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
module periodic_sphere_contact (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // first_radius, second_radius, zero fill
    input  wire logic [psc_pkg::S_TDATA_W-1:0]      s_tdata,
    // op
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // distance_sq, centre_distance, zero fill
    output logic [psc_pkg::M_TDATA_W-1:0]           m_tdata,
    // touching
    output logic                                    m_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [psc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CB = psc_pkg::COORD_BITS;

    logic [psc_pkg::BOX_W-1:0] box_edge_reg, box_edge_next;
    logic [psc_pkg::EPS_W-1:0] contact_epsilon_reg, contact_epsilon_next;

    psc_pkg::cfg_t      cfg;
    psc_pkg::pair_t     pair;
    psc_pkg::geom_out_t geom_res;
    logic               geom_valid;
    logic               geom_ready;
    logic [psc_pkg::DSQ_W-1:0]  out_dsq;
    logic [psc_pkg::DIST_W-1:0] out_dist;

    always_comb begin
        box_edge_next        = box_edge_reg;
        contact_epsilon_next = contact_epsilon_reg;
        if (cfg_valid) begin
            case (cfg_index)
                psc_pkg::CFG_BOX_EDGE: begin
                    box_edge_next = cfg_data[psc_pkg::BOX_W-1:0];
                end
                psc_pkg::CFG_CONTACT_EPS: begin
                    contact_epsilon_next = cfg_data[psc_pkg::EPS_W-1:0];
                end
                default: begin
                    box_edge_next = box_edge_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_edge_reg        <= psc_pkg::BOX_RESET;
            contact_epsilon_reg <= psc_pkg::EPS_RESET;
        end else begin
            box_edge_reg        <= box_edge_next;
            contact_epsilon_reg <= contact_epsilon_next;
        end
    end

    assign cfg_ready           = 1'b1;
    assign cfg.box_edge        = box_edge_reg;
    assign cfg.contact_epsilon = contact_epsilon_reg;

    always_comb begin
        pair.periodic = !s_tuser;
        for (int i = 0; i < 3; i++) begin
            pair.first[i]  = s_tdata[i*CB +: CB];
            pair.second[i] = s_tdata[(3+i)*CB +: CB];
        end
        pair.first_radius  = s_tdata[6*CB +: psc_pkg::RAD_W];
        pair.second_radius = s_tdata[6*CB + psc_pkg::RAD_W +: psc_pkg::RAD_W];
    end

    psc_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pair   (pair),
        .out_valid (geom_valid),
        .out_ready (geom_ready),
        .out_res   (geom_res)
    );

    psc_sqrt u_sqrt (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (geom_valid),
        .in_ready     (geom_ready),
        .in_res       (geom_res),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_dsq      (out_dsq),
        .out_dist     (out_dist),
        .out_touching (m_tuser)
    );

    assign m_tdata = psc_pkg::M_TDATA_W'({out_dist, out_dsq});

endmodule
`default_nettype wire
